// ===== rtl/sdo_bdf_pkg.sv =====
// Types, codes and constants shared by the SDO block download framer.
// No dependencies; imported by every module of the block except sdo_bdf_fifo.
`default_nettype none

package sdo_bdf_pkg;

    localparam int unsigned IMAGE_LENGTH_W = 24;
    localparam int unsigned NODE_W         = 7;
    localparam int unsigned CFG_DATA_W     = 24;

    // item kinds as they arrive, reused as internal operation codes
    typedef logic [1:0] op_t;
    localparam op_t OP_START = 2'd0;
    localparam op_t OP_BYTE  = 2'd1;
    localparam op_t OP_RESP  = 2'd2;
    localparam op_t OP_BAD   = 2'd3;

    typedef logic [2:0] status_t;
    localparam status_t ST_PROGRESS   = 3'd0;
    localparam status_t ST_DONE       = 3'd1;
    localparam status_t ST_ABORT      = 3'd2;
    localparam status_t ST_UNEXPECTED = 3'd3;
    localparam status_t ST_REJECTED   = 3'd4;

    // configuration register indexes
    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t REG_NODE_NUMBER  = 1'b0;
    localparam cfg_index_t REG_IMAGE_LENGTH = 1'b1;

    localparam logic [10:0] SDO_RX_BASE   = 11'h600;
    localparam logic [7:0]  CMD_INITIATE  = 8'hC6;
    localparam logic [7:0]  IDX_LOW       = 8'h50;
    localparam logic [7:0]  IDX_HIGH      = 8'h1F;
    localparam logic [7:0]  CMD_ABORT     = 8'h80;
    localparam logic [7:0]  CMD_BLOCK_ACK = 8'hA2;
    localparam logic [7:0]  CMD_END_OK    = 8'hA1;
    localparam logic [7:0]  CMD_END       = 8'hC1;
    localparam logic [7:0]  LAST_FLAG     = 8'h80;
    localparam logic [15:0] CRC_POLY      = 16'h1021;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] response_command;
    } item_t;

    typedef struct packed {
        logic        frame_valid;
        logic [10:0] frame_identifier;
        logic [7:0]  frame_byte_zero;
        logic [7:0]  frame_byte_one;
        logic [7:0]  frame_byte_two;
        logic [7:0]  frame_byte_three;
        logic [7:0]  frame_byte_four;
        logic [7:0]  frame_byte_five;
        logic [7:0]  frame_byte_six;
        logic [7:0]  frame_byte_seven;
        status_t     status;
    } result_t;

    // classified item handed from front to back
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       is_abort;
        logic       is_ack;
        logic       is_end_ok;
    } cmd_t;

    // CRC-16/XMODEM, one byte, MSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sdo_bdf_fifo.sv =====
// Small register-based queue with push/full and pop/empty sides.
// No dependencies; used between front and back and on the result side.
`default_nettype none

module sdo_bdf_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic                  empty,
    output logic      [WIDTH-1:0] rdata
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sdo_bdf_front.sv =====
// Front end: takes input beats, classifies them and queues them for the engine.
// Depends on sdo_bdf_pkg and sdo_bdf_fifo.
`default_nettype none

module sdo_bdf_front
    import sdo_bdf_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire item_t item,
    input  wire logic  pop,
    output logic       empty,
    output cmd_t       cmd
);

    cmd_t cls;

    // response bytes are pre-decoded so the engine only selects
    always_comb
    begin
        cls.op        = op_t'(item.kind);
        cls.data      = (item.kind == OP_BYTE) ? item.data_byte : item.response_command;
        cls.is_abort  = (item.response_command == CMD_ABORT);
        cls.is_ack    = (item.response_command == CMD_BLOCK_ACK);
        cls.is_end_ok = (item.response_command == CMD_END_OK);
    end

    sdo_bdf_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .wdata (cls),
        .pop   (pop),
        .empty (empty),
        .rdata (cmd)
    );

endmodule

`default_nettype wire

// ===== rtl/sdo_bdf_back.sv =====
// Protocol engine: SDO block download sequencing, segment packing and CRC.
// Depends on sdo_bdf_pkg.
`default_nettype none

module sdo_bdf_back
    import sdo_bdf_pkg::*;
#(
    parameter int unsigned SEGMENTS_PER_BLOCK = 127,
    parameter int unsigned LENGTH_BITS        = 24
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire cfg_index_t            wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    input  wire logic                  take,
    input  wire cmd_t                  cmd,
    output result_t                    res
);

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_WAIT_INIT = 3'd1;
    localparam logic [2:0] PH_DATA      = 3'd2;
    localparam logic [2:0] PH_WAIT_ACK  = 3'd3;
    localparam logic [2:0] PH_WAIT_END  = 3'd4;

    localparam logic [6:0] SEG_LIMIT = 7'(SEGMENTS_PER_BLOCK);
    localparam logic [2:0] SEG_BYTES = 3'd7;

    logic [2:0]             phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] bytes_reg, bytes_next;
    logic [2:0]             fill_reg, fill_next;
    logic [6:0]             seq_reg, seq_next;
    logic [15:0]            crc_reg, crc_next;
    logic [2:0]             unused_reg, unused_next;
    logic [NODE_W-1:0]      node_reg;
    logic [IMAGE_LENGTH_W-1:0] length_reg;
    logic [7:0]             seg_buf_reg [7];

    logic [LENGTH_BITS-1:0] len;
    logic [LENGTH_BITS:0]   bytes_inc;
    logic                   last;
    logic [2:0]             fill_inc;
    logic [6:0]             seq_inc;
    logic [7:0]             fb [8];
    logic                   fvalid;
    status_t                st;

    assign len       = length_reg[LENGTH_BITS-1:0];
    assign bytes_inc = {1'b0, bytes_reg} + 1'b1;
    assign last      = (bytes_inc >= {1'b0, len});
    assign fill_inc  = fill_reg + 1'b1;
    assign seq_inc   = seq_reg + 1'b1;

    always_comb
    begin
        phase_next  = phase_reg;
        bytes_next  = bytes_reg;
        fill_next   = fill_reg;
        seq_next    = seq_reg;
        crc_next    = crc_reg;
        unused_next = unused_reg;
        fvalid      = 1'b0;
        st          = ST_PROGRESS;
        for (int i = 0; i < 8; i++)
        begin
            fb[i] = 8'h00;
        end

        if (take)
        begin
            unique case (cmd.op)
                OP_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        bytes_next  = '0;
                        fill_next   = '0;
                        seq_next    = '0;
                        crc_next    = '0;
                        unused_next = '0;
                        fvalid      = 1'b1;
                        fb[0]       = CMD_INITIATE;
                        fb[1]       = IDX_LOW;
                        fb[2]       = IDX_HIGH;
                        fb[4]       = 8'(len);
                        fb[5]       = 8'(24'(len) >> 8);
                        fb[6]       = 8'(24'(len) >> 16);
                        phase_next  = PH_WAIT_INIT;
                    end
                    else
                    begin
                        st = ST_REJECTED;
                    end
                end
                OP_BYTE:
                begin
                    if (phase_reg == PH_DATA && bytes_reg < len && fill_reg < SEG_BYTES)
                    begin
                        bytes_next = bytes_inc[LENGTH_BITS-1:0];
                        crc_next   = crc16_step(crc_reg, cmd.data);
                        fill_next  = fill_inc;
                        if (fill_inc == SEG_BYTES || last)
                        begin
                            fvalid = 1'b1;
                            fb[0]  = {last, seq_inc};
                            for (int i = 0; i < 7; i++)
                            begin
                                if (3'(i) == fill_reg)
                                begin
                                    fb[i+1] = cmd.data;
                                end
                                else if (3'(i) < fill_reg)
                                begin
                                    fb[i+1] = seg_buf_reg[i];
                                end
                            end
                            fill_next = '0;
                            seq_next  = seq_inc;
                            // unused bytes of the closing segment, for the end frame
                            if (last)
                            begin
                                unused_next = SEG_BYTES - fill_inc;
                            end
                            if (last || seq_inc >= SEG_LIMIT)
                            begin
                                phase_next = PH_WAIT_ACK;
                            end
                        end
                    end
                    else
                    begin
                        st = ST_REJECTED;
                    end
                end
                OP_RESP:
                begin
                    unique case (phase_reg)
                        PH_WAIT_INIT:
                        begin
                            if (cmd.is_abort)
                            begin
                                phase_next = PH_IDLE;
                                st         = ST_ABORT;
                            end
                            else if (len == '0)
                            begin
                                fvalid     = 1'b1;
                                fb[0]      = CMD_END + {3'b000, unused_reg, 2'b00};
                                fb[1]      = crc_reg[7:0];
                                fb[2]      = crc_reg[15:8];
                                phase_next = PH_WAIT_END;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                        PH_WAIT_ACK:
                        begin
                            if (cmd.is_ack)
                            begin
                                seq_next = '0;
                                if (bytes_reg >= len)
                                begin
                                    fvalid     = 1'b1;
                                    fb[0]      = CMD_END + {3'b000, unused_reg, 2'b00};
                                    fb[1]      = crc_reg[7:0];
                                    fb[2]      = crc_reg[15:8];
                                    phase_next = PH_WAIT_END;
                                end
                                else
                                begin
                                    phase_next = PH_DATA;
                                end
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                st         = cmd.is_abort ? ST_ABORT : ST_UNEXPECTED;
                            end
                        end
                        PH_WAIT_END:
                        begin
                            phase_next = PH_IDLE;
                            if (cmd.is_end_ok)
                            begin
                                st = ST_DONE;
                            end
                            else if (cmd.is_abort)
                            begin
                                st = ST_ABORT;
                            end
                            else
                            begin
                                st = ST_UNEXPECTED;
                            end
                        end
                        default:
                        begin
                            st = ST_REJECTED;
                        end
                    endcase
                end
                default:
                begin
                    st = ST_REJECTED;
                end
            endcase
        end
    end

    always_comb
    begin
        res.frame_valid      = fvalid;
        res.frame_identifier = fvalid ? (SDO_RX_BASE + {4'b0000, node_reg}) : 11'h000;
        res.frame_byte_zero  = fb[0];
        res.frame_byte_one   = fb[1];
        res.frame_byte_two   = fb[2];
        res.frame_byte_three = fb[3];
        res.frame_byte_four  = fb[4];
        res.frame_byte_five  = fb[5];
        res.frame_byte_six   = fb[6];
        res.frame_byte_seven = fb[7];
        res.status           = st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            bytes_reg  <= '0;
            fill_reg   <= '0;
            seq_reg    <= '0;
            crc_reg    <= '0;
            unused_reg <= '0;
            node_reg   <= NODE_W'(1);
            length_reg <= IMAGE_LENGTH_W'(1);
        end
        else
        begin
            phase_reg  <= phase_next;
            bytes_reg  <= bytes_next;
            fill_reg   <= fill_next;
            seq_reg    <= seq_next;
            crc_reg    <= crc_next;
            unused_reg <= unused_next;
            // registers are locked while a download is under way
            if (wr_en && phase_reg == PH_IDLE)
            begin
                unique case (wr_index)
                    REG_NODE_NUMBER:  node_reg   <= wr_data[NODE_W-1:0];
                    REG_IMAGE_LENGTH: length_reg <= wr_data[IMAGE_LENGTH_W-1:0];
                    default:          node_reg   <= node_reg;
                endcase
            end
        end
    end

    // segment buffer: bytes past the fill point are masked on read
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 7; i++)
        begin
            if (take && cmd.op == OP_BYTE && phase_reg == PH_DATA && fill_reg == 3'(i))
            begin
                seg_buf_reg[i] <= cmd.data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sdo_block_download_framer.sv =====
// SDO block download framer, client side, for object 0x1F50. One input beat is
// a start request, one firmware byte or the command byte of a received server
// reply; every input beat yields exactly one result beat, which carries a CAN
// frame to send (initiate, segment or end frame) and/or a status. Input and
// result sides are both queues, two deep each, so a stall on either side is
// absorbed for a few beats before it reaches the other: with pop held low,
// full rises once four beats are waiting (two results, two in the front queue).
// Throughput is one beat per clock while the result queue has room, as the
// engine finishes every item in the cycle it takes it. An accepted input beat
// is registered in the front queue; the engine writes its result straight
// into the result queue, whose registers drive the result ports. The engine
// updates the CRC-16/XMODEM and segment buffer in the same cycle it takes a byte.
// node_number and image_length are written through wr_en/wr_index/wr_data and
// are ignored while a download is in progress (any phase other than idle).
// Depends on sdo_bdf_pkg, sdo_bdf_fifo, sdo_bdf_front and sdo_bdf_back.
`default_nettype none

module sdo_block_download_framer
    import sdo_bdf_pkg::*;
#(
    parameter int unsigned SEGMENTS_PER_BLOCK = 127,
    parameter int unsigned LENGTH_BITS        = 24
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input queue side
    input  wire logic                  push,
    output logic                       full,
    input  wire item_t                 item,
    // result queue side
    output logic                       empty,
    input  wire logic                  pop,
    output result_t                    result,
    // configuration writes
    input  wire logic                  wr_en,
    input  wire cfg_index_t            wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data
);

    cmd_t    cmd;
    logic    cmd_empty;
    logic    res_full;
    logic    take;
    result_t res;

    // engine moves one beat whenever there is one and room to put its result
    assign take = !cmd_empty && !res_full;

    sdo_bdf_front #(
        .QUEUE_DEPTH (2)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .pop   (take),
        .empty (cmd_empty),
        .cmd   (cmd)
    );

    sdo_bdf_back #(
        .SEGMENTS_PER_BLOCK (SEGMENTS_PER_BLOCK),
        .LENGTH_BITS        (LENGTH_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .take     (take),
        .cmd      (cmd),
        .res      (res)
    );

    // result queue decouples the engine from a stalled consumer
    sdo_bdf_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (2)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (take),
        .full  (res_full),
        .wdata (res),
        .pop   (pop),
        .empty (empty),
        .rdata (result)
    );

    // a result without a frame carries an all-zero identifier
    a_no_frame_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !res.frame_valid) |-> (res.frame_identifier == 11'h000))
        else $error("frameless result with non-zero identifier");

    // a rejected item never produces a frame
    a_reject_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (take && res.status == ST_REJECTED) |-> !res.frame_valid)
        else $error("rejected item produced a frame");

    // an item taken by the engine leaves the result queue non-empty next cycle
    a_result_queued: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> !empty)
        else $error("engine result lost");

    // a start item into the engine either opens a download or is rejected
    a_start_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        (take && cmd.op == OP_START) |->
            ((res.frame_valid && res.frame_byte_zero == CMD_INITIATE)
             || res.status == ST_REJECTED))
        else $error("start item gave no initiate frame and no rejection");

endmodule

`default_nettype wire
